FILE: rtl/core/adm_pkg.sv
// adm_pkg: shared types and constants for the adjacency matrix depth-first walker
// used by adm_walk_engine and adjacency_matrix_dfs; depends on nothing else
package adm_pkg;

    localparam int ADM_VERTICES = 16;
    localparam int ROW_W        = 16;
    localparam int VTX_W        = 4;
    localparam int CNT_W        = 5;
    localparam int NEXT_W       = 5;
    localparam int KIND_W       = 2;

    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WALK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [CNT_W-1:0] VERTEX_COUNT_RESET = 5'd16;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [VTX_W-1:0]  row_index;
        logic [ROW_W-1:0]  row_bits;
        logic [VTX_W-1:0]  start_vertex;
    } t_item;

    typedef struct packed {
        logic [CNT_W-1:0] vertex_number;
        logic             last;
    } t_result;

    // walk engine to output stage: a newly visited vertex, or the end of a walk
    typedef struct packed {
        logic             push;
        logic             finish;
        logic [VTX_W-1:0] vertex;
    } t_emit;

endpackage

FILE: rtl/core/adm_walk_engine.sv
// adm_walk_engine: adjacency rows, visited marks, walk stack and the scan sequencer
// one neighbour test per cycle while scanning, with pops of finished frames in between; depends on adm_pkg
module adm_walk_engine #(
    parameter int VERTICES = adm_pkg::ADM_VERTICES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  adm_pkg::t_item             i_item,
    input  logic [adm_pkg::CNT_W-1:0]  i_vertex_count,
    output logic                       o_busy,
    output adm_pkg::t_emit             o_emit
);
    import adm_pkg::*;

    // only the first STACK vertices (VERTICES, capped at sixteen) can ever be addressed or walked
    localparam int STACK = (VERTICES < ROW_W) ? VERTICES : ROW_W;
    localparam int SW    = $clog2(STACK);
    localparam int DW    = $clog2(STACK + 1);
    localparam int ENT_W = NEXT_W + VTX_W;

    localparam logic [CNT_W-1:0] STACK_CNT = CNT_W'(STACK);
    localparam logic [DW-1:0]    STACK_DEP = DW'(STACK);
    localparam logic [DW-1:0]    DEP_ONE   = DW'(1);
    localparam logic [DW-1:0]    DEP_TWO   = DW'(2);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                r_state;
    logic [DW-1:0]       r_depth;
    logic [STACK-1:0]    r_visited;
    logic [ROW_W-1:0]    r_rows [STACK];
    logic [ENT_W-1:0]    r_stack [STACK];
    logic [VTX_W-1:0]    r_cur;
    logic [NEXT_W-1:0]   r_next;

    logic [CNT_W-1:0]    w_active;
    logic [ROW_W-1:0]    w_row;
    logic                w_in_range;
    logic                w_hit;
    logic                w_room;
    logic                w_pop;
    logic                w_start_ok;
    logic                w_walk;
    logic [DW-1:0]       w_depth_m1;
    logic [DW-1:0]       w_depth_m2;

    assign w_active   = (i_vertex_count > STACK_CNT) ? STACK_CNT : i_vertex_count;
    assign w_row      = r_rows[r_cur[SW-1:0]];
    assign w_in_range = r_next < w_active;
    assign w_hit      = w_in_range && w_row[r_next[VTX_W-1:0]] && !r_visited[r_next[SW-1:0]];
    assign w_room     = r_depth < STACK_DEP;
    // an unvisited neighbour with no stack room still ends this frame
    assign w_pop      = !w_in_range || (w_hit && !w_room);
    assign w_depth_m1 = r_depth - DEP_ONE;
    assign w_depth_m2 = r_depth - DEP_TWO;

    assign w_start_ok = ({1'b0, i_item.start_vertex} < w_active)
                        && !r_visited[i_item.start_vertex[SW-1:0]];
    assign w_walk     = i_accept && (i_item.kind == KIND_WALK) && w_start_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_depth   <= '0;
            r_visited <= '0;
            for (int i = 0; i < STACK; i++) begin
                r_rows[i] <= '0;
            end
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_accept) begin
                        case (i_item.kind)
                            KIND_LOAD: begin
                                if ({1'b0, i_item.row_index} < STACK_CNT) begin
                                    r_rows[i_item.row_index[SW-1:0]] <= i_item.row_bits;
                                end
                            end
                            KIND_WALK: begin
                                if (w_start_ok) begin
                                    r_visited[i_item.start_vertex[SW-1:0]] <= 1'b1;
                                    r_depth <= DEP_ONE;
                                    r_state <= ST_SCAN;
                                end
                            end
                            KIND_CLEAR: begin
                                r_visited <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (w_hit && w_room) begin
                        r_visited[r_next[SW-1:0]] <= 1'b1;
                        r_depth <= r_depth + DEP_ONE;
                    end else if (w_pop) begin
                        r_depth <= w_depth_m1;
                        if (r_depth == DEP_ONE) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // top of stack lives in r_cur / r_next, the frames below it in r_stack
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            if (w_walk) begin
                r_cur  <= i_item.start_vertex;
                r_next <= '0;
            end
        end else if (w_hit && w_room) begin
            r_stack[w_depth_m1[SW-1:0]] <= {r_next + NEXT_W'(1), r_cur};
            r_cur  <= r_next[VTX_W-1:0];
            r_next <= '0;
        end else if (w_pop) begin
            if (r_depth != DEP_ONE) begin
                {r_next, r_cur} <= r_stack[w_depth_m2[SW-1:0]];
            end
        end else begin
            r_next <= r_next + NEXT_W'(1);
        end
    end

    assign o_busy        = (r_state == ST_SCAN);
    assign o_emit.push   = (r_state == ST_IDLE) ? w_walk : (w_hit && w_room);
    assign o_emit.finish = (r_state == ST_SCAN) && w_pop && (r_depth == DEP_ONE);
    assign o_emit.vertex = (r_state == ST_IDLE) ? i_item.start_vertex : r_next[VTX_W-1:0];

    a_depth_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_depth != '0 && r_depth <= STACK_DEP))
        else $error("walk stack depth out of bounds");

    a_push_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit.push |=> r_visited[$past(o_emit.vertex[SW-1:0])])
        else $error("emitted vertex not marked visited");

    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit.finish |=> (r_state == ST_IDLE) && (r_depth == '0))
        else $error("walk finished with frames left");

endmodule

FILE: rtl/core/adjacency_matrix_dfs.sv
// adjacency_matrix_dfs: top level, APB register, result stage and walk engine
// depends on adm_pkg and adm_walk_engine
//
//  channel   | signals                                  | transaction
//  ----------+------------------------------------------+--------------------------------
//  command   | start, busy, i_item                      | start high while busy low
//  result    | o_valid, o_result                        | o_valid high for one cycle
//  register  | psel penable pwrite paddr pwdata prdata  | write at access with pready high
//
// load and clear transactions take effect when accepted; busy stays low
// a walk tests one neighbour position at a time in a single-bit scan loop, and pops
// a stack frame once its row is exhausted or no stack room is left
// each result waits until its successor is found and is then registered out; the final one at the last pop
// reset is synchronous: rows and visited marks cleared, vertex_count back to 16
// the receiver cannot stall; results are never held
module adjacency_matrix_dfs #(
    parameter int VERTICES = adm_pkg::ADM_VERTICES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  adm_pkg::t_item     i_item,
    output logic               o_valid,
    output adm_pkg::t_result   o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import adm_pkg::*;

    localparam logic REG_VERTEX_COUNT = 1'b0;

    logic [CNT_W-1:0]  r_vertex_count;
    logic              r_pend_valid;
    logic [VTX_W-1:0]  r_pend_vertex;
    logic              r_out_valid;
    t_result           r_out;

    logic              w_accept;
    logic              w_busy;
    logic              w_cfg_write;
    t_emit             w_emit;

    assign w_accept    = start && !w_busy;
    assign w_cfg_write = psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VERTEX_COUNT_RESET;
        end else if (w_cfg_write) begin
            r_vertex_count <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? {{(32 - CNT_W){1'b0}}, r_vertex_count}
                                                   : '0;
    assign pready = 1'b1;

    adm_walk_engine #(
        .VERTICES (VERTICES)
    ) u_walk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_item         (i_item),
        .i_vertex_count (r_vertex_count),
        .o_busy         (w_busy),
        .o_emit         (w_emit)
    );

    // the newest vertex waits here until the walk shows whether it is the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= (w_emit.push && r_pend_valid) || w_emit.finish;
            if (w_emit.push) begin
                r_pend_valid <= 1'b1;
            end else if (w_emit.finish) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit.push) begin
            r_pend_vertex <= w_emit.vertex;
        end
        if (w_emit.push || w_emit.finish) begin
            r_out.vertex_number <= CNT_W'(r_pend_vertex) + CNT_W'(1);
            r_out.last          <= w_emit.finish;
        end
    end

    assign busy     = w_busy;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_busy |-> !r_pend_valid)
        else $error("vertex left pending while idle");

    a_finish_has_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit.finish |-> r_pend_valid)
        else $error("walk finished with nothing to send");

    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past((w_emit.push && r_pend_valid) || w_emit.finish))
        else $error("result strobe without cause");

endmodule

FILE: bench/adjacency_matrix_dfs_tb.sv
`timescale 1ns / 100ps
// adjacency_matrix_dfs_tb: self-checking bench for the depth-first walker, with its own
// shadow of matrix rows, visited marks and vertex count predicting every visit
// depends on adm_pkg and the adjacency_matrix_dfs top level
module adjacency_matrix_dfs_tb;
    import adm_pkg::*;

    localparam logic [2:0]        ADDR_VERTEX_COUNT = 3'd0;
    localparam logic [2:0]        ADDR_SPARE        = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SPARE        = 2'd3;
    localparam int                ITEM_W            = $bits(t_item);
    localparam int                WALK_CYCLES       = ADM_VERTICES * (ADM_VERTICES + 1) + 8;
    localparam int                MAX_SHOWN         = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_item       cmd_item;
    logic        o_valid;
    t_result     o_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // shadow state
    logic [ROW_W-1:0]        matrix_rows [ADM_VERTICES];
    logic [ADM_VERTICES-1:0] seen_mask;
    logic [CNT_W-1:0]        live_count;
    t_result                 pending_visits [$];
    int                      mismatch_count;
    int                      sender_idle_pct;

    adjacency_matrix_dfs dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (cmd_item),
        .o_valid  (o_valid),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // recursive preorder with ascending neighbours, kept as an explicit stack
    function automatic void dfs_order(input logic [VTX_W-1:0] root);
        int      n;
        int      depth;
        int      cur;
        int      nxt;
        int      count;
        int      last_idx;
        bit      found;
        int      stk_vtx  [ADM_VERTICES];
        int      stk_scan [ADM_VERTICES];
        t_result visit;
        n = (int'(live_count) > ADM_VERTICES) ? ADM_VERTICES : int'(live_count);
        if (int'(root) >= n || seen_mask[root]) return;
        seen_mask[root] = 1'b1;
        visit.vertex_number = CNT_W'(int'(root) + 1);
        visit.last = 1'b0;
        pending_visits.push_back(visit);
        count = 1;
        stk_vtx[0] = int'(root);
        stk_scan[0] = 0;
        depth = 1;
        while (depth > 0) begin
            cur = stk_vtx[depth-1];
            nxt = stk_scan[depth-1];
            found = 1'b0;
            while (nxt < n && !found) begin
                if (matrix_rows[cur][nxt] && !seen_mask[nxt]) found = 1'b1;
                nxt++;
            end
            stk_scan[depth-1] = nxt;
            if (found && depth < ADM_VERTICES && count < ROW_W) begin
                seen_mask[nxt-1] = 1'b1;
                visit.vertex_number = CNT_W'(nxt);
                visit.last = 1'b0;
                pending_visits.push_back(visit);
                count++;
                stk_vtx[depth] = nxt - 1;
                stk_scan[depth] = 0;
                depth++;
            end else begin
                depth--;
            end
        end
        last_idx = pending_visits.size() - 1;
        visit = pending_visits[last_idx];
        visit.last = 1'b1;
        pending_visits[last_idx] = visit;
    endfunction

    function automatic void predict_cmd(input t_item cmd);
        case (cmd.kind)
            KIND_LOAD:  matrix_rows[cmd.row_index] = cmd.row_bits;
            KIND_WALK:  dfs_order(cmd.start_vertex);
            KIND_CLEAR: seen_mask = '0;
            default: ;
        endcase
    endfunction

    function automatic t_item make_cmd(input logic [KIND_W-1:0] kind,
                                       input logic [VTX_W-1:0] row_index,
                                       input logic [ROW_W-1:0] row_bits,
                                       input logic [VTX_W-1:0] start_vertex);
        t_item cmd;
        cmd.kind = kind;
        cmd.row_index = row_index;
        cmd.row_bits = row_bits;
        cmd.start_vertex = start_vertex;
        return cmd;
    endfunction

    function automatic t_item random_cmd();
        t_item cmd;
        int    pick;
        cmd = ITEM_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 45) cmd.kind = KIND_LOAD;
        else if (pick < 85) cmd.kind = KIND_WALK;
        else if (pick < 95) cmd.kind = KIND_CLEAR;
        else cmd.kind = KIND_SPARE;
        // sparse rows give long chains and back edges rather than a full fan-out
        if (cmd.kind == KIND_LOAD && $urandom_range(1) == 1)
            cmd.row_bits = ROW_W'(1 << $urandom_range(15)) | ROW_W'(1 << $urandom_range(15));
        return cmd;
    endfunction

    // start stays high across back-to-back transactions; lowered only for a gap or by wait_idle
    task automatic send_cmd(input t_item cmd);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        start <= 1'b1;
        cmd_item <= cmd;
        do @(posedge i_clk); while (busy);
        predict_cmd(cmd);
    endtask

    // drain outstanding visits, then allow for a walk that emits nothing
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_visits.size() != 0) @(posedge i_clk);
        do @(posedge i_clk); while (busy);
        repeat (WALK_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_VERTEX_COUNT) live_count = data[CNT_W-1:0];
    endtask

    task automatic test_directed_walks();
        sender_idle_pct = 0;
        send_cmd(make_cmd(KIND_WALK, 4'd0, 16'h0000, 4'd0));
        send_cmd(make_cmd(KIND_WALK, 4'd15, 16'hFFFF, 4'd0));
        send_cmd(make_cmd(KIND_LOAD, 4'd0, 16'hFFFF, 4'd15));
        send_cmd(make_cmd(KIND_WALK, 4'd0, 16'h0000, 4'd1));
        send_cmd(make_cmd(KIND_CLEAR, 4'd15, 16'hFFFF, 4'd15));
        send_cmd(make_cmd(KIND_WALK, 4'd0, 16'h0000, 4'd0));
        send_cmd(make_cmd(KIND_SPARE, 4'd15, 16'hFFFF, 4'd0));
        send_cmd(make_cmd(KIND_WALK, 4'd0, 16'h0000, 4'd5));
        // hold off until every visit of the full walk is back
        wait_idle();
        send_cmd(make_cmd(KIND_CLEAR, 4'd0, 16'h0000, 4'd0));
        send_cmd(make_cmd(KIND_LOAD, 4'd15, 16'h8000, 4'd0));
        send_cmd(make_cmd(KIND_WALK, 4'd0, 16'h0000, 4'd15));
        // 2 -> 4 -> 2 back edge, 4 -> 9 -> 3
        send_cmd(make_cmd(KIND_LOAD, 4'd2, 16'h0010, 4'd0));
        send_cmd(make_cmd(KIND_LOAD, 4'd4, 16'h0204, 4'd0));
        send_cmd(make_cmd(KIND_LOAD, 4'd9, 16'h0008, 4'd0));
        send_cmd(make_cmd(KIND_WALK, 4'd0, 16'h0000, 4'd2));
        send_cmd(make_cmd(KIND_LOAD, 4'd0, 16'h0000, 4'd0));
        send_cmd(make_cmd(KIND_CLEAR, 4'd0, 16'h0000, 4'd0));
        send_cmd(make_cmd(KIND_WALK, 4'd0, 16'h0000, 4'd0));
        send_cmd(make_cmd(KIND_WALK, 4'd0, 16'h0000, 4'd2));
    endtask

    task automatic test_vertex_count_limits();
        sender_idle_pct = 0;
        wait_idle();
        reg_write(ADDR_VERTEX_COUNT, 32'd0);
        send_cmd(make_cmd(KIND_CLEAR, 4'd0, 16'h0000, 4'd0));
        send_cmd(make_cmd(KIND_WALK, 4'd0, 16'h0000, 4'd0));
        send_cmd(make_cmd(KIND_WALK, 4'd0, 16'h0000, 4'd15));
        wait_idle();
        // unmapped register must leave the count alone
        reg_write(ADDR_SPARE, 32'h0000_0003);
        send_cmd(make_cmd(KIND_WALK, 4'd0, 16'h0000, 4'd0));
        wait_idle();
        // upper data bits dropped, leaving a count of one
        reg_write(ADDR_VERTEX_COUNT, 32'hFFFF_FFE1);
        send_cmd(make_cmd(KIND_LOAD, 4'd0, 16'hFFFF, 4'd0));
        send_cmd(make_cmd(KIND_WALK, 4'd0, 16'h0000, 4'd0));
        send_cmd(make_cmd(KIND_CLEAR, 4'd0, 16'h0000, 4'd0));
        send_cmd(make_cmd(KIND_WALK, 4'd0, 16'h0000, 4'd1));
        send_cmd(make_cmd(KIND_WALK, 4'd0, 16'h0000, 4'd0));
        wait_idle();
        reg_write(ADDR_VERTEX_COUNT, 32'd31);
        send_cmd(make_cmd(KIND_CLEAR, 4'd0, 16'h0000, 4'd0));
        send_cmd(make_cmd(KIND_WALK, 4'd0, 16'h0000, 4'd15));
        send_cmd(make_cmd(KIND_WALK, 4'd0, 16'h0000, 4'd0));
    endtask

    task automatic test_random_traffic(input logic [31:0] count_val, input int idle_pct,
                                       input int items);
        wait_idle();
        reg_write(ADDR_VERTEX_COUNT, count_val);
        sender_idle_pct = idle_pct;
        repeat (items) send_cmd(random_cmd());
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            if (pending_visits.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN)
                    $display("unexpected visit: vertex %0d last %0b",
                             o_result.vertex_number, o_result.last);
            end else begin
                want = pending_visits.pop_front();
                if (o_result.vertex_number !== want.vertex_number
                        || o_result.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN)
                        $display("visit mismatch: expected vertex %0d last %0b, got %0d last %0b",
                                 want.vertex_number, want.last,
                                 o_result.vertex_number, o_result.last);
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        i_rst_n <= 1'b0;
        start <= 1'b0;
        cmd_item <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        foreach (matrix_rows[i]) matrix_rows[i] = '0;
        seen_mask = '0;
        live_count = VERTEX_COUNT_RESET;
        mismatch_count = 0;
        sender_idle_pct = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_walks();
        test_vertex_count_limits();
        test_random_traffic(32'd16, 0, 95);
        test_random_traffic(32'd7, 80, 85);
        test_random_traffic(32'd31, 29, 85);
        test_random_traffic(32'd1, 0, 35);
        test_random_traffic(32'd0, 29, 25);
        test_random_traffic(32'd12, 80, 25);
        wait_idle();

        if (mismatch_count == 0 && pending_visits.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/adm_pkg.sv
rtl/core/adm_walk_engine.sv
rtl/core/adjacency_matrix_dfs.sv
bench/adjacency_matrix_dfs_tb.sv
